// File: design/tlb_pkg.sv
package tlb_pkg;

   // Table geometry
   localparam int KNOTS   = 256;
   localparam int KNOT_AW = $clog2(KNOTS);
   localparam int KNOT_CW = KNOT_AW + 1;

   // Divider geometry: 64-bit dividend, one quotient bit per cycle
   localparam int PROD_W    = 64;
   localparam int DIV_CW    = $clog2(PROD_W);
   localparam int QUO_LIMIT = 40;

   // Request modes
   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_QUERY = 2'd1;
   localparam logic [1:0] MODE_BLEND = 2'd2;

   // Configuration register indexes
   localparam int         CSR_AW       = 1;
   localparam logic [CSR_AW-1:0] CSR_TIME_OLD = 1'd0;
   localparam logic [CSR_AW-1:0] CSR_TIME_NEW = 1'd1;

   // One table entry
   typedef struct packed {
      logic signed [31:0] pos;
      logic signed [31:0] val;
   } knot_type;

   // Operands of base + a*b/d
   typedef struct packed {
      logic signed [31:0] base;
      logic signed [32:0] a;
      logic signed [32:0] b;
      logic signed [32:0] d;
   } md_op_type;

   typedef struct packed {
      logic busy;
      logic done;
   } md_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAUNCH,
      ST_CALC,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      MD_IDLE,
      MD_MAG,
      MD_MUL,
      MD_DIV,
      MD_FIN
   } md_state_type;

endpackage

// File: design/tlb_if.sv
interface tlb_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic [7:0]         knot_index;
   logic signed [31:0] knot_position;
   logic signed [31:0] knot_value;
   logic signed [31:0] query_position;
   logic signed [31:0] old_value;
   logic signed [31:0] new_value;
   logic signed [31:0] time_now;

   modport source (
      output valid, mode, knot_index, knot_position, knot_value,
             query_position, old_value, new_value, time_now,
      input  ready
   );
   modport sink (
      input  valid, mode, knot_index, knot_position, knot_value,
             query_position, old_value, new_value, time_now,
      output ready
   );
endinterface

interface tlb_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result_value;
   logic               hit;

   modport source (output valid, result_value, hit, input ready);
   modport sink (input valid, result_value, hit, output ready);
endinterface

interface tlb_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: design/tlb_knot_ram.sv
module tlb_knot_ram (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [tlb_pkg::KNOT_AW-1:0]   wr_addr,
   input  tlb_pkg::knot_type             wr_data,
   input  logic                          rd_en,
   input  logic [tlb_pkg::KNOT_AW-1:0]   rd_addr,
   output tlb_pkg::knot_type             rd_data
);
   import tlb_pkg::*;

   knot_type mem [KNOTS];
   knot_type rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/tlb_muldiv.sv
module tlb_muldiv (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  tlb_pkg::md_op_type    op,
   output tlb_pkg::md_status_type status,
   output logic signed [31:0]    result
);
   import tlb_pkg::*;

   localparam logic signed [41:0] SUM_MAX = 42'sd2147483647;
   localparam logic signed [41:0] SUM_MIN = -42'sd2147483648;

   md_state_type       state_ff, state_in;
   md_op_type          op_ff, op_in;
   logic               neg_ff, neg_in;
   logic [31:0]        ua_ff, ua_in;
   logic [31:0]        ub_ff, ub_in;
   logic [31:0]        ud_ff, ud_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [PROD_W-1:0]  quo_ff, quo_in;
   logic [31:0]        rem_ff, rem_in;
   logic [DIV_CW-1:0]  cnt_ff, cnt_in;
   logic signed [31:0] result_ff, result_in;
   logic               done_ff, done_in;

   logic signed [32:0] neg_a, neg_b, neg_d;
   logic [32:0]        r2, rdiff;
   logic               ge;
   logic               over;
   logic signed [41:0] smag, sq, sum;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         MD_IDLE: if (start) state_in = MD_MAG;
         MD_MAG:  state_in = MD_MUL;
         MD_MUL:  state_in = MD_DIV;
         MD_DIV:  if (cnt_ff == '0) state_in = MD_FIN;
         MD_FIN:  state_in = MD_IDLE;
         default: state_in = MD_IDLE;
      endcase
   end

   // Restoring division step
   always_comb begin
      r2    = {rem_ff, prod_ff[PROD_W-1]};
      ge    = r2 >= {1'b0, ud_ff};
      rdiff = r2 - {1'b0, ud_ff};
   end

   // Quotient limit, sign and saturating add
   always_comb begin
      over = |quo_ff[PROD_W-1:QUO_LIMIT];
      smag = $signed({2'b00, quo_ff[QUO_LIMIT-1:0]});
      sq   = neg_ff ? -smag : smag;
      sum  = 42'(op_ff.base) + sq;
   end

   always_comb begin
      neg_a = -op_ff.a;
      neg_b = -op_ff.b;
      neg_d = -op_ff.d;
   end

   // Datapath
   always_comb begin
      op_in     = op_ff;
      neg_in    = neg_ff;
      ua_in     = ua_ff;
      ub_in     = ub_ff;
      ud_in     = ud_ff;
      prod_in   = prod_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      result_in = result_ff;
      done_in   = 1'b0;
      case (state_ff)
         MD_IDLE: begin
            if (start) op_in = op;
         end
         MD_MAG: begin
            neg_in = (op_ff.a[32] ^ op_ff.b[32]) ^ op_ff.d[32];
            ua_in  = op_ff.a[32] ? neg_a[31:0] : op_ff.a[31:0];
            ub_in  = op_ff.b[32] ? neg_b[31:0] : op_ff.b[31:0];
            ud_in  = op_ff.d[32] ? neg_d[31:0] : op_ff.d[31:0];
         end
         MD_MUL: begin
            prod_in = ua_ff * ub_ff;
            quo_in  = '0;
            rem_in  = '0;
            cnt_in  = DIV_CW'(PROD_W - 1);
         end
         MD_DIV: begin
            prod_in = {prod_ff[PROD_W-2:0], 1'b0};
            quo_in  = {quo_ff[PROD_W-2:0], ge};
            rem_in  = ge ? rdiff[31:0] : r2[31:0];
            cnt_in  = cnt_ff - 1'b1;
         end
         MD_FIN: begin
            done_in = 1'b1;
            if (over) begin
               result_in = neg_ff ? 32'sh80000000 : 32'sh7FFFFFFF;
            end else if (sum > SUM_MAX) begin
               result_in = 32'sh7FFFFFFF;
            end else if (sum < SUM_MIN) begin
               result_in = 32'sh80000000;
            end else begin
               result_in = sum[31:0];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      op_ff     <= op_in;
      neg_ff    <= neg_in;
      ua_ff     <= ua_in;
      ub_ff     <= ub_in;
      ud_ff     <= ud_in;
      prod_ff   <= prod_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      cnt_ff    <= cnt_in;
      result_ff <= result_in;
   end

   assign status.busy = (state_ff != MD_IDLE);
   assign status.done = done_ff;
   assign result      = result_ff;

endmodule

// File: design/table_lerp_and_time_blend.sv
// Piecewise-linear table lookup and time blend, signed Q15.16.
// req_ch carries one item per handshake: mode 0 stores a knot (position,
// value) at knot_index, mode 1 interpolates the table at query_position,
// mode 2 blends old_value and new_value at time_now between the time_old
// and time_new registers. Modes 0 and 3 give no result; modes 1 and 2 give
// one item on rsp_ch (result_value, hit). csr_ch writes time_old (index 0)
// and time_new (index 1); it is always ready.
// A query reads all 256 table entries through the one read port of the
// knot memory, one per cycle, then runs the shared multiply/divide unit, a
// 64-step bit-serial divider, when a segment matches. A blend skips the
// scan and uses the divider only when the time stamps differ. Only one
// item is in flight at a time.
// The result sits in an output register; while the receiver stalls it is
// held and no new item is taken once the next result is finished.
// Reset clears the control state and both time registers; table contents
// stay undefined until written, so load every knot before querying.
module table_lerp_and_time_blend (
   input logic     clock,
   input logic     reset,
   tlb_req_if.sink   req_ch,
   tlb_rsp_if.source rsp_ch,
   tlb_csr_if.sink   csr_ch
);
   import tlb_pkg::*;

   state_type          state_ff, state_in;
   logic [1:0]         mode_ff, mode_in;
   logic signed [31:0] query_ff, query_in;
   logic signed [31:0] old_ff, old_in;
   logic signed [31:0] new_ff, new_in;
   logic signed [31:0] now_ff, now_in;
   logic signed [31:0] time_old_ff, time_old_in;
   logic signed [31:0] time_new_ff, time_new_in;
   logic [KNOT_CW-1:0] scan_cnt_ff, scan_cnt_in;
   logic               rd_vld_ff, rd_vld_in;
   logic               rd_first_ff, rd_first_in;
   knot_type           prev_ff, prev_in;
   knot_type           m0_ff, m0_in;
   knot_type           m1_ff, m1_in;
   logic               match_ff, match_in;
   logic signed [31:0] res_ff, res_in;
   logic               hit_ff, hit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_value_ff, rsp_value_in;
   logic               rsp_hit_ff, rsp_hit_in;

   logic          req_accept, csr_accept;
   logic          ram_wr_en, scan_issue, scan_done;
   knot_type      ram_wr_data, ram_rd_data;
   logic          seg_match, need_div;
   logic          md_start, rsp_load;
   md_op_type     md_op;
   md_status_type md_status;
   logic signed [31:0] md_result;

   assign req_accept = req_ch.valid & req_ch.ready;
   assign csr_accept = csr_ch.valid & csr_ch.ready;

   assign scan_done = (state_ff == ST_SCAN) && !scan_issue && !rd_vld_ff;
   assign need_div  = (mode_ff == MODE_QUERY) ? match_ff
                                              : (time_new_ff != time_old_ff);
   assign seg_match = rd_vld_ff && !rd_first_ff &&
                      (query_ff > prev_ff.pos) && (query_ff < ram_rd_data.pos);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_ch.mode)
                  MODE_QUERY: state_in = ST_SCAN;
                  MODE_BLEND: state_in = ST_LAUNCH;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN:   if (scan_done) state_in = ST_LAUNCH;
         ST_LAUNCH: state_in = need_div ? ST_CALC : ST_OUT;
         ST_CALC:   if (md_status.done) state_in = ST_OUT;
         ST_OUT:    if (rsp_load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      req_ch.ready = (state_ff == ST_IDLE);
      csr_ch.ready = 1'b1;
      ram_wr_en    = req_accept && (req_ch.mode == MODE_LOAD) &&
                     (32'(req_ch.knot_index) < 32'(KNOTS));
      scan_issue   = (state_ff == ST_SCAN) &&
                     (scan_cnt_ff != KNOT_CW'(KNOTS));
      md_start     = (state_ff == ST_LAUNCH) && need_div;
      rsp_load     = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ch.ready);
      if (mode_ff == MODE_QUERY) begin
         md_op.base = m0_ff.val;
         md_op.a    = 33'(m1_ff.val) - 33'(m0_ff.val);
         md_op.b    = 33'(query_ff) - 33'(m0_ff.pos);
         md_op.d    = 33'(m1_ff.pos) - 33'(m0_ff.pos);
      end else begin
         md_op.base = old_ff;
         md_op.a    = 33'(new_ff) - 33'(old_ff);
         md_op.b    = 33'(now_ff) - 33'(time_old_ff);
         md_op.d    = 33'(time_new_ff) - 33'(time_old_ff);
      end
   end

   assign ram_wr_data.pos = req_ch.knot_position;
   assign ram_wr_data.val = req_ch.knot_value;

   // Item capture and configuration
   always_comb begin
      mode_in     = mode_ff;
      query_in    = query_ff;
      old_in      = old_ff;
      new_in      = new_ff;
      now_in      = now_ff;
      time_old_in = time_old_ff;
      time_new_in = time_new_ff;
      if (req_accept) begin
         mode_in  = req_ch.mode;
         query_in = req_ch.query_position;
         old_in   = req_ch.old_value;
         new_in   = req_ch.new_value;
         now_in   = req_ch.time_now;
      end
      if (csr_accept && csr_ch.index == CSR_TIME_OLD) time_old_in = csr_ch.data;
      if (csr_accept && csr_ch.index == CSR_TIME_NEW) time_new_in = csr_ch.data;
   end

   // Table scan: entry i arrives in the cycle after its read, compared to i-1
   always_comb begin
      scan_cnt_in = scan_cnt_ff;
      rd_vld_in   = scan_issue;
      rd_first_in = scan_issue && (scan_cnt_ff == '0);
      prev_in     = rd_vld_ff ? ram_rd_data : prev_ff;
      m0_in       = m0_ff;
      m1_in       = m1_ff;
      match_in    = match_ff;
      if (req_accept) begin
         scan_cnt_in = '0;
         match_in    = 1'b0;
      end else if (scan_issue) begin
         scan_cnt_in = scan_cnt_ff + 1'b1;
      end
      // later segments overwrite earlier ones
      if (seg_match) begin
         m0_in    = prev_ff;
         m1_in    = ram_rd_data;
         match_in = 1'b1;
      end
   end

   // Result and output register
   always_comb begin
      res_in = res_ff;
      hit_in = hit_ff;
      if (state_ff == ST_LAUNCH && !need_div) begin
         res_in = (mode_ff == MODE_QUERY) ? 32'sd0 : old_ff;
         hit_in = 1'b0;
      end else if (state_ff == ST_CALC && md_status.done) begin
         res_in = md_result;
         hit_in = 1'b1;
      end
      rsp_valid_in = rsp_load | (rsp_valid_ff & !rsp_ch.ready);
      rsp_value_in = rsp_load ? res_ff : rsp_value_ff;
      rsp_hit_in   = rsp_load ? hit_ff : rsp_hit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         time_old_ff  <= '0;
         time_new_ff  <= '0;
         scan_cnt_ff  <= '0;
         rd_vld_ff    <= 1'b0;
         rd_first_ff  <= 1'b0;
         match_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         time_old_ff  <= time_old_in;
         time_new_ff  <= time_new_in;
         scan_cnt_ff  <= scan_cnt_in;
         rd_vld_ff    <= rd_vld_in;
         rd_first_ff  <= rd_first_in;
         match_ff     <= match_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff      <= mode_in;
      query_ff     <= query_in;
      old_ff       <= old_in;
      new_ff       <= new_in;
      now_ff       <= now_in;
      prev_ff      <= prev_in;
      m0_ff        <= m0_in;
      m1_ff        <= m1_in;
      res_ff       <= res_in;
      hit_ff       <= hit_in;
      rsp_value_ff <= rsp_value_in;
      rsp_hit_ff   <= rsp_hit_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.result_value = rsp_value_ff;
   assign rsp_ch.hit          = rsp_hit_ff;

   tlb_knot_ram u_knot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req_ch.knot_index[KNOT_AW-1:0]),
      .wr_data (ram_wr_data),
      .rd_en   (scan_issue),
      .rd_addr (scan_cnt_ff[KNOT_AW-1:0]),
      .rd_data (ram_rd_data)
   );

   tlb_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .start  (md_start),
      .op     (md_op),
      .status (md_status),
      .result (md_result)
   );

`ifndef SYNTHESIS
   a_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      md_status.done |-> state_ff == ST_CALC)
      else $error("muldiv finished outside the calc state");

   a_start_launch: assert property (@(posedge clock) disable iff (reset)
      md_start |-> (mode_ff == MODE_QUERY || mode_ff == MODE_BLEND))
      else $error("muldiv started for a mode without a result");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !md_status.busy && !rd_vld_ff)
      else $error("work still in flight while idle");

   a_out_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && state_in == ST_IDLE) |=> rsp_valid_ff)
      else $error("result dropped on the way to the output register");
`endif

endmodule

// File: bench/tlb_result_checker.sv
// Watches the request, result and register channels of the table/blend
// block, keeps its own copy of the knot table and time stamps, works out
// the result of each query and blend, and compares every returned item.
module tlb_result_checker (
   input  logic clock,
   input  logic reset,
   tlb_req_if   req_ch,
   tlb_rsp_if   rsp_ch,
   tlb_csr_if   csr_ch,
   output int   mismatch_count,
   output int   results_due,
   output int   results_checked,
   output int   hits_checked
);
   import tlb_pkg::*;

   typedef struct {
      logic [1:0]         mode;
      logic signed [31:0] value;
      logic               hit;
   } lerp_result_type;

   localparam logic signed [31:0] WORD_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] WORD_MIN = 32'sh80000000;
   localparam longint             SAT_MAX  = 64'sd2147483647;
   localparam longint             SAT_MIN  = -64'sd2147483648;

   logic signed [31:0] knot_pos [KNOTS];
   logic signed [31:0] knot_val [KNOTS];
   logic signed [31:0] t_old;
   logic signed [31:0] t_new;
   lerp_result_type    lerp_due_q [$];

   initial begin
      foreach (knot_pos[i]) begin
         knot_pos[i] = '0;
         knot_val[i] = '0;
      end
      t_old = '0;
      t_new = '0;
   end

   // base + a*b/d, exact product, quotient toward zero, clamp to 32 bits
   function automatic logic signed [31:0] lerp_saturate(longint base, longint a,
                                                        longint b, longint d);
      logic         neg;
      logic [63:0]  ma;
      logic [63:0]  mb;
      logic [63:0]  md;
      logic [127:0] quo;
      longint       sum;
      neg = ((a < 0) != (b < 0)) != (d < 0);
      ma  = (a < 0) ? -a : a;
      mb  = (b < 0) ? -b : b;
      md  = (d < 0) ? -d : d;
      quo = ({64'd0, ma} * {64'd0, mb}) / {64'd0, md};
      if (quo >= (128'd1 << QUO_LIMIT))
         return neg ? WORD_MIN : WORD_MAX;
      sum = neg ? base - longint'(quo[63:0]) : base + longint'(quo[63:0]);
      if (sum > SAT_MAX)
         return WORD_MAX;
      if (sum < SAT_MIN)
         return WORD_MIN;
      return sum[31:0];
   endfunction

   // scan every segment; strict bounds, the last match wins
   function automatic lerp_result_type table_lookup(logic signed [31:0] q);
      lerp_result_type r;
      longint          qq;
      longint          p0;
      longint          p1;
      longint          v0;
      longint          v1;
      r.mode  = MODE_QUERY;
      r.value = '0;
      r.hit   = 1'b0;
      qq      = q;
      for (int s = 0; s + 1 < KNOTS; s++) begin
         p0 = knot_pos[s];
         p1 = knot_pos[s + 1];
         if (qq > p0 && qq < p1) begin
            v0      = knot_val[s];
            v1      = knot_val[s + 1];
            r.value = lerp_saturate(v0, v1 - v0, qq - p0, p1 - p0);
            r.hit   = 1'b1;
         end
      end
      return r;
   endfunction

   // blend between the two time stamps; equal stamps pass old through
   function automatic lerp_result_type time_blend(logic signed [31:0] ov,
                                                  logic signed [31:0] nv,
                                                  logic signed [31:0] tn);
      lerp_result_type r;
      longint          o;
      longint          n;
      longint          t;
      longint          t0;
      longint          t1;
      o      = ov;
      n      = nv;
      t      = tn;
      t0     = t_old;
      t1     = t_new;
      r.mode = MODE_BLEND;
      if (t1 == t0) begin
         r.value = ov;
         r.hit   = 1'b0;
      end else begin
         r.value = lerp_saturate(o, n - o, t - t0, t1 - t0);
         r.hit   = 1'b1;
      end
      return r;
   endfunction

   // one pass per edge: compare returned item, note register writes, then take new requests
   always @(posedge clock) begin : watch
      int              errs;
      lerp_result_type want;
      errs = 0;
      if (reset) begin
         t_old = '0;
         t_new = '0;
         lerp_due_q.delete();
         mismatch_count  <= 0;
         results_due     <= 0;
         results_checked <= 0;
         hits_checked    <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (lerp_due_q.size() == 0) begin
               $display("%0t: unexpected result item value %h hit %b", $time,
                        rsp_ch.result_value, rsp_ch.hit);
               errs++;
            end else begin
               want = lerp_due_q.pop_front();
               if (rsp_ch.result_value !== want.value) begin
                  $display("%0t: mode %0d result_value expected %h, got %h", $time,
                           want.mode, want.value, rsp_ch.result_value);
                  errs++;
               end
               if (rsp_ch.hit !== want.hit) begin
                  $display("%0t: mode %0d hit expected %b, got %b", $time,
                           want.mode, want.hit, rsp_ch.hit);
                  errs++;
               end
               results_checked <= results_checked + 1;
               if (want.hit)
                  hits_checked <= hits_checked + 1;
            end
         end

         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_TIME_OLD: t_old = csr_ch.data;
               CSR_TIME_NEW: t_new = csr_ch.data;
               default: ;
            endcase
         end

         if (req_ch.valid && req_ch.ready) begin
            case (req_ch.mode)
               MODE_LOAD: begin
                  if (req_ch.knot_index < KNOTS) begin
                     knot_pos[req_ch.knot_index] = req_ch.knot_position;
                     knot_val[req_ch.knot_index] = req_ch.knot_value;
                  end
               end
               MODE_QUERY: lerp_due_q.push_back(table_lookup(req_ch.query_position));
               MODE_BLEND: lerp_due_q.push_back(time_blend(req_ch.old_value,
                                                           req_ch.new_value,
                                                           req_ch.time_now));
               default: ;
            endcase
         end

         mismatch_count <= mismatch_count + errs;
         results_due    <= lerp_due_q.size();
      end
   end

endmodule

// File: bench/table_lerp_and_time_blend_test.sv
module table_lerp_and_time_blend_test;
   import tlb_pkg::*;

   typedef enum logic [1:0] {
      PACE_STEADY,
      PACE_SEND_IDLE,
      PACE_RECV_STALL,
      PACE_BOTH
   } pace_type;

   typedef enum logic [1:0] {
      SHAPE_RAMP,
      SHAPE_SCATTER,
      SHAPE_STEPS
   } table_shape_type;

   typedef struct {
      logic [1:0]         mode;
      logic [7:0]         knot_index;
      logic signed [31:0] knot_position;
      logic signed [31:0] knot_value;
      logic signed [31:0] query_position;
      logic signed [31:0] old_value;
      logic signed [31:0] new_value;
      logic signed [31:0] time_now;
   } req_item_type;

   localparam logic [1:0]         MODE_IGNORED  = 2'd3;
   localparam logic signed [31:0] WORD_MAX      = 32'sh7fffffff;
   localparam logic signed [31:0] WORD_MIN      = 32'sh80000000;
   localparam logic signed [31:0] ONE_Q16       = 32'sh00010000;
   localparam int                 RANDOM_ITEMS  = 780;
   localparam int                 BLOCK_ITEMS   = 60;
   localparam int                 SETTLE_CYCLES = 400;

   logic clock = 1'b0;
   logic reset;

   tlb_req_if req_ch ();
   tlb_rsp_if rsp_ch ();
   tlb_csr_if csr_ch ();

   int req_gap_pct;
   int rsp_stall_pct;
   int mode_count [4];
   int csr_writes;
   int mismatch_count;
   int results_due;
   int results_checked;
   int hits_checked;

   logic signed [31:0] cfg_old;
   logic signed [31:0] cfg_new;
   logic signed [31:0] pos_shadow [KNOTS];
   table_shape_type    slot_shape [KNOTS];

   table_lerp_and_time_blend u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   tlb_result_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .csr_ch          (csr_ch),
      .mismatch_count  (mismatch_count),
      .results_due     (results_due),
      .results_checked (results_checked),
      .hits_checked    (hits_checked)
   );

   always #2 clock = ~clock;

   // result side back-pressure
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // give up on a hung run
   initial begin
      #12_000_000;
      $display("timeout with %0d results still outstanding", results_due);
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic void set_pace(pace_type pace);
      case (pace)
         PACE_STEADY:     begin req_gap_pct = 0;  rsp_stall_pct = 0;  end
         PACE_SEND_IDLE:  begin req_gap_pct = 68; rsp_stall_pct = 0;  end
         PACE_RECV_STALL: begin req_gap_pct = 0;  rsp_stall_pct = 68; end
         default:         begin req_gap_pct = 22; rsp_stall_pct = 22; end
      endcase
   endfunction

   // random word leaning on the extremes
   function automatic logic signed [31:0] rand_word();
      int pick;
      pick = $urandom_range(99);
      if (pick < 8)
         return WORD_MAX;
      if (pick < 16)
         return WORD_MIN;
      if (pick < 20)
         return '0;
      if (pick < 24)
         return '1;
      return $urandom;
   endfunction

   // all fields random; constructors below override what matters
   function automatic req_item_type noise_item();
      req_item_type it;
      it.mode           = 2'($urandom_range(3));
      it.knot_index     = 8'($urandom);
      it.knot_position  = $urandom;
      it.knot_value     = $urandom;
      it.query_position = $urandom;
      it.old_value      = $urandom;
      it.new_value      = $urandom;
      it.time_now       = $urandom;
      return it;
   endfunction

   function automatic req_item_type load_item(logic [7:0] idx, logic signed [31:0] p,
                                              logic signed [31:0] v);
      req_item_type it;
      it               = noise_item();
      it.mode          = MODE_LOAD;
      it.knot_index    = idx;
      it.knot_position = p;
      it.knot_value    = v;
      return it;
   endfunction

   function automatic req_item_type query_item(logic signed [31:0] q);
      req_item_type it;
      it                = noise_item();
      it.mode           = MODE_QUERY;
      it.query_position = q;
      return it;
   endfunction

   function automatic req_item_type blend_item(logic signed [31:0] ov,
                                               logic signed [31:0] nv,
                                               logic signed [31:0] tn);
      req_item_type it;
      it           = noise_item();
      it.mode      = MODE_BLEND;
      it.old_value = ov;
      it.new_value = nv;
      it.time_now  = tn;
      return it;
   endfunction

   // knot for slot i of a given table shape
   function automatic void knot_for(table_shape_type shape, int i,
                                    output logic signed [31:0] pos,
                                    output logic signed [31:0] val);
      longint p;
      case (shape)
         SHAPE_RAMP: p = -64'sd2147483648 + longint'(i) * 64'sd16777216
                         + longint'($urandom_range(8388607));
         SHAPE_SCATTER: p = longint'($urandom_range(8191)) - 4096;
         default: p = longint'(i / 2) * 1000 - 64000;
      endcase
      pos = p[31:0];
      val = rand_word();
      // full-scale swings between neighbors
      if (shape == SHAPE_RAMP && (i == 10 || i == 12))
         val = WORD_MAX;
      if (shape == SHAPE_RAMP && i == 11)
         val = WORD_MIN;
   endfunction

   function automatic logic signed [31:0] seg_mid(int s);
      longint m;
      m = (longint'(pos_shadow[s]) + longint'(pos_shadow[s + 1])) / 2;
      return m[31:0];
   endfunction

   // mostly inside a segment, some on a knot, some anywhere
   function automatic logic signed [31:0] aim_query();
      int     pick;
      int     s;
      longint lo;
      longint hi;
      longint q;
      pick = $urandom_range(99);
      s    = $urandom_range(KNOTS - 2);
      lo   = pos_shadow[s];
      hi   = pos_shadow[s + 1];
      if (pick < 60 && hi > lo + 1) begin
         q = lo + 1 + longint'($urandom) % (hi - lo - 1);
         return q[31:0];
      end
      if (pick < 75)
         return pos_shadow[s + pick % 2];
      return rand_word();
   endfunction

   // time inside the configured span, on its ends, or anywhere
   function automatic logic signed [31:0] aim_time();
      int     pick;
      longint lo;
      longint hi;
      longint t;
      pick = $urandom_range(99);
      lo   = (cfg_old < cfg_new) ? cfg_old : cfg_new;
      hi   = (cfg_old < cfg_new) ? cfg_new : cfg_old;
      if (pick < 45)
         t = lo + longint'($urandom) % (hi - lo + 1);
      else if (pick < 55)
         t = cfg_old;
      else if (pick < 65)
         t = cfg_new;
      else
         t = rand_word();
      return t[31:0];
   endfunction

   function automatic req_item_type random_item();
      int                 pick;
      int                 idx;
      logic signed [31:0] p;
      logic signed [31:0] v;
      logic signed [31:0] ov;
      pick = $urandom_range(99);
      if (pick < 3) begin
         random_item      = noise_item();
         random_item.mode = MODE_IGNORED;
      end else if (pick < 15) begin
         idx = $urandom_range(KNOTS - 1);
         knot_for(slot_shape[idx], idx, p, v);
         pos_shadow[idx] = p;
         random_item     = load_item(idx[7:0], p, v);
      end else if (pick < 58) begin
         random_item = query_item(aim_query());
      end else begin
         ov = rand_word();
         if (pick < 70)
            random_item = blend_item(ov, ov + (int'($urandom_range(4095)) - 2048),
                                     aim_time());
         else
            random_item = blend_item(ov, rand_word(), aim_time());
      end
   endfunction

   // present one item at the falling edge, hold until taken
   task automatic send_item(input req_item_type it);
      @(negedge clock);
      while ($urandom_range(99) < req_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.mode           <= it.mode;
      req_ch.knot_index     <= it.knot_index;
      req_ch.knot_position  <= it.knot_position;
      req_ch.knot_value     <= it.knot_value;
      req_ch.query_position <= it.query_position;
      req_ch.old_value      <= it.old_value;
      req_ch.new_value      <= it.new_value;
      req_ch.time_now       <= it.time_now;
      mode_count[it.mode]++;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
   endtask

   // stop sending, drain all results, let a trailing load finish
   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (results_due != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_AW-1:0] idx, input logic signed [31:0] data);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      @(posedge clock);
      while (!csr_ch.ready)
         @(posedge clock);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      csr_writes++;
   endtask

   task automatic apply_times(input logic signed [31:0] t_old,
                              input logic signed [31:0] t_new);
      settle();
      write_csr(CSR_TIME_OLD, t_old);
      write_csr(CSR_TIME_NEW, t_new);
      cfg_old = t_old;
      cfg_new = t_new;
   endtask

   task automatic fill_window(input table_shape_type shape, input int first,
                              input int count);
      logic signed [31:0] p;
      logic signed [31:0] v;
      for (int i = first; i < first + count; i++) begin
         knot_for(shape, i, p, v);
         slot_shape[i] = shape;
         pos_shadow[i] = p;
         send_item(load_item(i[7:0], p, v));
      end
   endtask

   initial begin : stimulus
      int           random_sent;
      int           blk_num;
      req_item_type it;

      // known levels on every input from time zero
      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.mode           = MODE_LOAD;
      req_ch.knot_index     = '0;
      req_ch.knot_position  = '0;
      req_ch.knot_value     = '0;
      req_ch.query_position = '0;
      req_ch.old_value      = '0;
      req_ch.new_value      = '0;
      req_ch.time_now       = '0;
      rsp_ch.ready          = 1'b0;
      csr_ch.valid          = 1'b0;
      csr_ch.index          = CSR_TIME_OLD;
      csr_ch.data           = '0;
      cfg_old               = '0;
      cfg_new               = '0;
      csr_writes            = 0;
      foreach (mode_count[i])
         mode_count[i] = 0;
      set_pace(PACE_STEADY);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // equal times straight out of reset, and an unused mode
      send_item(blend_item(WORD_MAX, WORD_MIN, 32'sh00012345));
      it      = noise_item();
      it.mode = MODE_IGNORED;
      send_item(it);

      // whole table written before the first lookup
      fill_window(SHAPE_RAMP, 0, KNOTS);

      // below, above, on knots, just inside, full-scale segments, last segment
      send_item(query_item(WORD_MIN));
      send_item(query_item(WORD_MAX));
      send_item(query_item(pos_shadow[0]));
      send_item(query_item(pos_shadow[100]));
      send_item(query_item(pos_shadow[3] + 1));
      send_item(query_item(seg_mid(10)));
      send_item(query_item(seg_mid(11)));
      send_item(query_item(seg_mid(KNOTS - 2)));
      send_item(query_item(pos_shadow[KNOTS - 1] - 1));
      send_item(query_item(pos_shadow[KNOTS - 1]));

      // unit time span: midpoint, extrapolation both ways, falling blend
      apply_times('0, ONE_Q16);
      send_item(blend_item('0, ONE_Q16, 32'sh00008000));
      send_item(blend_item('0, WORD_MAX, WORD_MAX));
      send_item(blend_item(WORD_MAX, WORD_MIN, WORD_MIN));
      send_item(blend_item(-ONE_Q16, ONE_Q16, -32'sh00008000));

      // widest reversed span
      apply_times(WORD_MAX, WORD_MIN);
      send_item(blend_item(WORD_MIN, WORD_MAX, '0));
      send_item(blend_item(32'sd100, 32'sd200, WORD_MIN));

      // one-lsb span: quotient far past the limit
      apply_times('0, 32'sd1);
      send_item(blend_item(WORD_MIN, WORD_MAX, WORD_MAX));
      send_item(blend_item(WORD_MAX, WORD_MIN, WORD_MIN));
      send_item(blend_item(32'sd5, 32'sd7, 32'sd1));

      // random part in blocks, each with its own times and pacing
      random_sent = 0;
      blk_num     = 0;
      while (random_sent < RANDOM_ITEMS) begin
         case (blk_num % 8)
            0: apply_times(WORD_MIN, WORD_MAX);
            1: apply_times(WORD_MAX, WORD_MIN);
            2: apply_times('0, 32'sd1);
            3: apply_times(32'sd1, '0);
            4: apply_times(-3 * ONE_Q16, 5 * ONE_Q16);
            5: apply_times('0, '0);
            6: apply_times(WORD_MIN, WORD_MIN);
            default: apply_times(rand_word(), rand_word());
         endcase
         set_pace(pace_type'((blk_num + blk_num / 8) % 4));

         // reshape parts of the table: overlaps, flat pairs, then back
         if (blk_num == 3) begin
            fill_window(SHAPE_SCATTER, 96, 64);
            random_sent += 64;
         end
         if (blk_num == 8) begin
            fill_window(SHAPE_STEPS, 200, 32);
            random_sent += 32;
         end
         if (blk_num == 10) begin
            fill_window(SHAPE_RAMP, 96, 64);
            random_sent += 64;
         end

         repeat (BLOCK_ITEMS) begin
            send_item(random_item());
            random_sent++;
         end
         blk_num++;
      end

      settle();

      $display("covered %0d knot loads, %0d table queries, %0d time blends, %0d mode-3 items",
               mode_count[MODE_LOAD], mode_count[MODE_QUERY], mode_count[MODE_BLEND],
               mode_count[MODE_IGNORED]);
      $display("%0d results checked (%0d hits), %0d register writes, 4 pacing profiles",
               results_checked, hits_checked, csr_writes);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
